### hdl/act_pkg.sv
// shared types, constants and helpers for the action call tokenizer
package act_pkg;

  // limits of the command line storage
  localparam int NAME_MAX    = 64;
  localparam int PARAM_BYTES = 1024;
  localparam int PARAM_MAX   = 64;

  // counter widths; the name and byte counter widths follow from the limits
  localparam int NAME_W = $clog2(NAME_MAX + 1);
  localparam int PB_W   = $clog2(PARAM_BYTES + 2);
  localparam int PS_W   = 7;

  // result queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // result kinds
  localparam logic [2:0] K_NAME  = 3'd0;
  localparam logic [2:0] K_PARAM = 3'd1;
  localparam logic [2:0] K_PEND  = 3'd2;
  localparam logic [2:0] K_OK    = 3'd3;
  localparam logic [2:0] K_ERROR = 3'd4;
  localparam logic [2:0] K_BLANK = 3'd5;

  // error codes
  localparam logic [1:0] E_NONE      = 2'd0;
  localparam logic [1:0] E_BAD_FIRST = 2'd0;
  localparam logic [1:0] E_NO_OPEN   = 2'd1;
  localparam logic [1:0] E_NO_CLOSE  = 2'd2;

  // special characters
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // parse phases
  typedef enum logic [3:0] {
    PH_GROUND      = 4'd0,
    PH_NAME        = 4'd1,
    PH_NAME_SP     = 4'd2,
    PH_LIST        = 4'd3,
    PH_PLAIN       = 4'd4,
    PH_QUOTED      = 4'd5,
    PH_ESCAPE      = 4'd6,
    PH_AFTER_PARAM = 4'd7,
    PH_AFTER_CLOSE = 4'd8,
    PH_DISCARD     = 4'd9
  } phase_t;

  // input beat
  typedef struct packed {
    logic [7:0] char_in;
    logic       is_end;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [6:0] param_total;
    logic [1:0] error_code;
    logic       last;
  } out_item_t;

  // one queue entry: the one or two results of an input beat
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } act_rec_t;

  // queue status seen by the top level and the back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic out_item_t mk_res(logic [2:0] kind, logic [7:0] data,
                                       logic [PS_W-1:0] pt, logic [1:0] err);
    out_item_t r;
    r.kind        = kind;
    r.data        = data;
    r.param_total = pt;
    r.error_code  = err;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

### hdl/act_front.sv
// front end: parse state machine, classifies each beat into queue records
module act_front
  import act_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  in_item_t item,
  output logic     push,
  output act_rec_t rec
);

  phase_t            phase, phase_next;
  logic [NAME_W-1:0] name_length, name_next;
  logic [PB_W-1:0]   param_bytes, bytes_next;
  logic [PS_W-1:0]   param_seen, seen_next;

  logic [7:0]      c;
  logic            sp, an, room;
  logic [PB_W-1:0] bytes_inc, b;
  logic [PS_W-1:0] seen_inc;
  logic [1:0]      n;
  out_item_t       r0, r1;

  assign c  = item.char_in;
  assign sp = is_space(c);
  assign an = is_alnum(c);

  // counter helpers
  assign room      = param_bytes < PARAM_BYTES;
  assign bytes_inc = room ? param_bytes + 1'b1 : param_bytes;
  assign seen_inc  = (param_seen < PARAM_MAX) ? param_seen + 1'b1 : param_seen;

  // next phase
  always_comb begin
    phase_next = phase;
    if (item.is_end) begin
      phase_next = PH_GROUND;
    end else begin
      unique case (phase)
        PH_GROUND, PH_AFTER_CLOSE: begin
          if (!sp) phase_next = an ? PH_NAME : PH_DISCARD;
        end
        PH_NAME: begin
          if (c == CH_LPAREN) phase_next = PH_LIST;
          else if (sp) phase_next = PH_NAME_SP;
          else if (!an) phase_next = PH_DISCARD;
        end
        PH_NAME_SP: begin
          if (c == CH_LPAREN) phase_next = PH_LIST;
          else if (!sp) phase_next = PH_DISCARD;
        end
        PH_LIST: begin
          if (sp || c == CH_COMMA) phase_next = PH_LIST;
          else if (c == CH_QUOTE) phase_next = PH_QUOTED;
          else if (c == CH_RPAREN) phase_next = PH_AFTER_CLOSE;
          else phase_next = PH_PLAIN;
        end
        PH_PLAIN: begin
          if (sp) phase_next = PH_AFTER_PARAM;
          else if (c == CH_RPAREN) phase_next = PH_AFTER_CLOSE;
          else if (c == CH_COMMA) phase_next = PH_LIST;
        end
        PH_QUOTED: begin
          if (c == CH_QUOTE) phase_next = PH_AFTER_PARAM;
          else if (c == CH_BSLASH) phase_next = PH_ESCAPE;
        end
        PH_ESCAPE: phase_next = PH_QUOTED;
        PH_AFTER_PARAM: begin
          if (c == CH_COMMA) phase_next = PH_LIST;
          else if (c == CH_RPAREN) phase_next = PH_AFTER_CLOSE;
          else if (!sp) phase_next = PH_DISCARD;
        end
        PH_DISCARD: phase_next = PH_DISCARD;
        default: phase_next = PH_DISCARD;
      endcase
    end
  end

  // results and counter updates
  always_comb begin
    n          = 2'd0;
    r0         = '0;
    r1         = '0;
    b          = param_bytes;
    name_next  = name_length;
    bytes_next = param_bytes;
    seen_next  = param_seen;
    if (item.is_end) begin
      unique case (phase)
        PH_GROUND: begin
          r0 = mk_res(K_BLANK, 8'd0, param_seen, E_NONE);
          n  = 2'd1;
        end
        PH_NAME, PH_NAME_SP: begin
          r0 = mk_res(K_OK, 8'd0, param_seen, E_NONE);
          n  = 2'd1;
        end
        PH_AFTER_CLOSE, PH_DISCARD: n = 2'd0;
        default: begin
          r0 = mk_res(K_ERROR, 8'd0, param_seen, E_NO_CLOSE);
          n  = 2'd1;
        end
      endcase
      name_next  = '0;
      bytes_next = '0;
      seen_next  = '0;
    end else begin
      unique case (phase)
        PH_GROUND, PH_AFTER_CLOSE: begin
          name_next  = '0;
          bytes_next = '0;
          seen_next  = '0;
          if (an) begin
            name_next = NAME_W'(1);
            r0        = mk_res(K_NAME, c, '0, E_NONE);
            n         = 2'd1;
          end else if (!sp) begin
            r0 = mk_res(K_ERROR, 8'd0, '0, E_BAD_FIRST);
            n  = 2'd1;
          end
        end
        PH_NAME: begin
          if (c != CH_LPAREN && !sp) begin
            if (an) begin
              if (name_length < NAME_MAX) begin
                name_next = name_length + 1'b1;
                r0        = mk_res(K_NAME, c, param_seen, E_NONE);
                n         = 2'd1;
              end
            end else begin
              r0         = mk_res(K_ERROR, 8'd0, param_seen, E_NO_OPEN);
              n          = 2'd1;
              name_next  = '0;
              bytes_next = '0;
              seen_next  = '0;
            end
          end
        end
        PH_NAME_SP: begin
          if (!sp && c != CH_LPAREN) begin
            r0         = mk_res(K_ERROR, 8'd0, param_seen, E_NO_OPEN);
            n          = 2'd1;
            name_next  = '0;
            bytes_next = '0;
            seen_next  = '0;
          end
        end
        PH_LIST: begin
          if (sp || c == CH_QUOTE) begin
            n = 2'd0;
          end else if (c == CH_COMMA) begin
            bytes_next = bytes_inc;
            seen_next  = seen_inc;
            r0         = mk_res(K_PEND, 8'd0, seen_inc, E_NONE);
            n          = 2'd1;
          end else if (c == CH_RPAREN) begin
            r0         = mk_res(K_OK, 8'd0, param_seen, E_NONE);
            n          = 2'd1;
            name_next  = '0;
            bytes_next = '0;
            seen_next  = '0;
          end else if (room) begin
            bytes_next = bytes_inc;
            r0         = mk_res(K_PARAM, c, param_seen, E_NONE);
            n          = 2'd1;
          end
        end
        PH_PLAIN: begin
          if (sp || c == CH_COMMA) begin
            bytes_next = bytes_inc;
            seen_next  = seen_inc;
            r0         = mk_res(K_PEND, 8'd0, seen_inc, E_NONE);
            n          = 2'd1;
          end else if (c == CH_RPAREN) begin
            r0         = mk_res(K_PEND, 8'd0, seen_inc, E_NONE);
            r1         = mk_res(K_OK, 8'd0, seen_inc, E_NONE);
            n          = 2'd2;
            name_next  = '0;
            bytes_next = '0;
            seen_next  = '0;
          end else if (room) begin
            bytes_next = bytes_inc;
            r0         = mk_res(K_PARAM, c, param_seen, E_NONE);
            n          = 2'd1;
          end
        end
        PH_QUOTED: begin
          if (c == CH_QUOTE) begin
            bytes_next = bytes_inc;
            seen_next  = seen_inc;
            r0         = mk_res(K_PEND, 8'd0, seen_inc, E_NONE);
            n          = 2'd1;
          end else if (c != CH_BSLASH && room) begin
            bytes_next = bytes_inc;
            r0         = mk_res(K_PARAM, c, param_seen, E_NONE);
            n          = 2'd1;
          end
        end
        PH_ESCAPE: begin
          // backslash kept unless a quote follows, each byte needs room
          if (c != CH_QUOTE && b < PARAM_BYTES) begin
            r0 = mk_res(K_PARAM, CH_BSLASH, param_seen, E_NONE);
            n  = 2'd1;
            b  = b + 1'b1;
          end
          if (b < PARAM_BYTES) begin
            if (n == 2'd0) r0 = mk_res(K_PARAM, c, param_seen, E_NONE);
            else r1 = mk_res(K_PARAM, c, param_seen, E_NONE);
            n = n + 2'd1;
            b = b + 1'b1;
          end
          bytes_next = b;
        end
        PH_AFTER_PARAM: begin
          if (!sp && c != CH_COMMA) begin
            if (c == CH_RPAREN) r0 = mk_res(K_OK, 8'd0, param_seen, E_NONE);
            else r0 = mk_res(K_ERROR, 8'd0, param_seen, E_NO_CLOSE);
            n          = 2'd1;
            name_next  = '0;
            bytes_next = '0;
            seen_next  = '0;
          end
        end
        PH_DISCARD: n = 2'd0;
        default: begin
          name_next  = '0;
          bytes_next = '0;
          seen_next  = '0;
        end
      endcase
    end
    // mark the final result of this beat
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
  end

  assign push    = take && (n != 2'd0);
  assign rec.two = (n == 2'd2);
  assign rec.r0  = r0;
  assign rec.r1  = r1;

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_GROUND;
      name_length <= '0;
      param_bytes <= '0;
      param_seen  <= '0;
    end else if (take) begin
      phase       <= phase_next;
      name_length <= name_next;
      param_bytes <= bytes_next;
      param_seen  <= seen_next;
    end
  end

endmodule

### hdl/act_fifo.sv
// short record queue between the parser and the result serializer
module act_fifo
  import act_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  act_rec_t wr_rec,
  input  logic     pop,
  output act_rec_t rd_rec,
  output q_stat_t  stat
);

  act_rec_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_rec     = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_rec;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    !stat.full && !stat.empty |-> wr_ptr == QPTR_W'(rd_ptr + count))
    else $error("queue pointers disagree with count");

endmodule

### hdl/act_back.sv
// back end: plays out the one or two results of each queue record
module act_back
  import act_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  act_rec_t  head,
  input  q_stat_t   stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic sel;
  logic beat;

  assign out_valid = !stat.empty;
  assign out_data  = sel ? head.r1 : head.r0;
  assign beat      = out_valid && out_ready;
  assign pop       = beat && (sel || !head.two);

  // second beat select
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (beat) begin
      sel <= !sel && head.two;
    end
  end

  a_sel_has_two: assert property (@(posedge clk) disable iff (rst)
    sel |-> !stat.empty && head.two)
    else $error("second beat without a two-result record");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sel && head.two |-> !out_data.last)
    else $error("first of two results marked last");

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |-> out_data.last)
    else $error("record retired before its last result");

endmodule

### hdl/action_call_tokenizer.sv
// top level of the action call tokenizer
//
// input channel: in_valid / in_ready / in_data, one character or an
// end-of-line mark per beat (in_data.is_end set, char_in ignored)
// output channel: out_valid / out_ready / out_data, one token per beat:
// name char, param char, param end, ok, error or blank; last marks the
// final token caused by an input beat
//
// the parser takes one input beat per cycle while the record queue has
// room; each beat is parsed in the cycle it is accepted and its one or
// two tokens are queued as one record; a beat with no token queues nothing
// the tokens of a beat are registered in the record queue and reach the
// output behind any older records
// a beat that yields two tokens sends them one after the other through
// the single output port
// when the receiver stalls, the four-entry queue fills and in_ready drops;
// beats that yield no token still need a free entry to be taken
// reset puts the parser at ground with all counts cleared and empties the
// queue
module action_call_tokenizer
  import act_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic     take, push, pop;
  act_rec_t wr_rec, rd_rec;
  q_stat_t  stat;

  assign in_ready = !stat.full;
  assign take     = in_valid && in_ready;

  // parser
  act_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (in_data),
    .push (push),
    .rec  (wr_rec)
  );

  // record queue
  act_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (rd_rec),
    .stat   (stat)
  );

  // result serializer
  act_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (rd_rec),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### bench/act_checker.sv
// checker for the action call tokenizer: predicts the tokens of each input beat and compares
module act_checker
  import act_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        tokens_waiting,
  output int        beats_seen,
  output int        tokens_seen,
  output int        status_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // parser state of the model
  phase_t      phase;
  logic [6:0]  name_len;
  logic [10:0] param_bytes;
  logic [6:0]  param_seen;

  // tokens of the beat being parsed, and the tokens still owed by the block
  out_item_t beat_tok [2];
  int        beat_n;
  out_item_t expected_tokens [$];
  out_item_t want_tok;

  function automatic bit blank_code(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit word_code(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // at most two tokens per beat; param_total is the count at the time of the token
  function void push_token(logic [2:0] kind, logic [7:0] data, logic [1:0] err);
    if (beat_n < 2) begin
      beat_tok[beat_n].kind        = kind;
      beat_tok[beat_n].data        = data;
      beat_tok[beat_n].param_total = param_seen;
      beat_tok[beat_n].error_code  = err;
      beat_tok[beat_n].last        = 1'b0;
      beat_n++;
    end
  endfunction

  function void clear_counts();
    name_len    = '0;
    param_bytes = '0;
    param_seen  = '0;
  endfunction

  // parameter bytes beyond the store are dropped silently
  function void add_param_char(logic [7:0] c);
    if (param_bytes < PARAM_BYTES) begin
      param_bytes++;
      push_token(K_PARAM, c, E_NONE);
    end
  endfunction

  // the end marker takes a byte if there is one and always emits
  function void end_param();
    if (param_bytes < PARAM_BYTES) param_bytes++;
    if (param_seen < PARAM_MAX) param_seen++;
    push_token(K_PEND, 8'd0, E_NONE);
  endfunction

  function void close_ok();
    push_token(K_OK, 8'd0, E_NONE);
    clear_counts();
    phase = PH_AFTER_CLOSE;
  endfunction

  function void raise_error(logic [1:0] code);
    push_token(K_ERROR, 8'd0, code);
    clear_counts();
    phase = PH_DISCARD;
  endfunction

  // advance the parser by one beat and queue what it emits
  function void tokenize_beat(in_item_t b);
    logic [7:0] c;
    c = b.char_in;
    beat_n = 0;
    if (b.is_end) begin
      case (phase)
        PH_GROUND: push_token(K_BLANK, 8'd0, E_NONE);
        PH_NAME, PH_NAME_SP: push_token(K_OK, 8'd0, E_NONE);
        PH_AFTER_CLOSE, PH_DISCARD: ;
        default: push_token(K_ERROR, 8'd0, E_NO_CLOSE);
      endcase
      clear_counts();
      phase = PH_GROUND;
    end else begin
      case (phase)
        PH_GROUND, PH_AFTER_CLOSE: begin
          clear_counts();
          if (!blank_code(c)) begin
            if (word_code(c)) begin
              name_len = 7'd1;
              push_token(K_NAME, c, E_NONE);
              phase = PH_NAME;
            end else begin
              raise_error(E_BAD_FIRST);
            end
          end
        end
        PH_NAME: begin
          if (c == CH_LPAREN) phase = PH_LIST;
          else if (blank_code(c)) phase = PH_NAME_SP;
          else if (word_code(c)) begin
            // overlong names lose their tail
            if (name_len < NAME_MAX) begin
              name_len++;
              push_token(K_NAME, c, E_NONE);
            end
          end else raise_error(E_NO_OPEN);
        end
        PH_NAME_SP: begin
          if (!blank_code(c)) begin
            if (c == CH_LPAREN) phase = PH_LIST;
            else raise_error(E_NO_OPEN);
          end
        end
        PH_LIST: begin
          if (!blank_code(c)) begin
            if (c == CH_QUOTE) phase = PH_QUOTED;
            else if (c == CH_COMMA) end_param();
            else if (c == CH_RPAREN) close_ok();
            else begin
              add_param_char(c);
              phase = PH_PLAIN;
            end
          end
        end
        PH_PLAIN: begin
          if (blank_code(c)) begin
            end_param();
            phase = PH_AFTER_PARAM;
          end else if (c == CH_RPAREN) begin
            end_param();
            close_ok();
          end else if (c == CH_COMMA) begin
            end_param();
            phase = PH_LIST;
          end else add_param_char(c);
        end
        PH_QUOTED: begin
          if (c == CH_QUOTE) begin
            end_param();
            phase = PH_AFTER_PARAM;
          end else if (c == CH_BSLASH) phase = PH_ESCAPE;
          else add_param_char(c);
        end
        PH_ESCAPE: begin
          // the backslash survives unless a quote follows it
          if (c != CH_QUOTE) add_param_char(CH_BSLASH);
          add_param_char(c);
          phase = PH_QUOTED;
        end
        PH_AFTER_PARAM: begin
          if (!blank_code(c)) begin
            if (c == CH_COMMA) phase = PH_LIST;
            else if (c == CH_RPAREN) close_ok();
            else raise_error(E_NO_CLOSE);
          end
        end
        PH_DISCARD: ;
        default: begin
          clear_counts();
          phase = PH_DISCARD;
        end
      endcase
    end
    if (beat_n > 0) beat_tok[beat_n-1].last = 1'b1;
    for (int i = 0; i < beat_n; i++) expected_tokens.push_back(beat_tok[i]);
  endfunction

  task report_mismatch(string msg);
    $display("%0t mismatch at token %0d: %s", $realtime, tokens_seen, msg);
    fail_count++;
  endtask

  // output beats are older than an input beat taken at the same edge, so compare first
  always @(posedge clk) begin
    if (rst) begin
      phase = PH_GROUND;
      clear_counts();
      expected_tokens.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("token with nothing expected, kind %0d data %0h",
                                    out_data.kind, out_data.data));
        end else begin
          want_tok = expected_tokens.pop_front();
          if (out_data.kind !== want_tok.kind)
            report_mismatch($sformatf("kind expected %0d got %0d",
                                      want_tok.kind, out_data.kind));
          if (out_data.data !== want_tok.data)
            report_mismatch($sformatf("data expected %0h got %0h",
                                      want_tok.data, out_data.data));
          if (out_data.param_total !== want_tok.param_total)
            report_mismatch($sformatf("param_total expected %0d got %0d",
                                      want_tok.param_total, out_data.param_total));
          if (out_data.error_code !== want_tok.error_code)
            report_mismatch($sformatf("error_code expected %0d got %0d",
                                      want_tok.error_code, out_data.error_code));
          if (out_data.last !== want_tok.last)
            report_mismatch($sformatf("last expected %0b got %0b",
                                      want_tok.last, out_data.last));
          if (want_tok.kind >= K_OK) status_seen++;
          tokens_seen++;
        end
      end
      if (in_valid && in_ready) begin
        beats_seen++;
        tokenize_beat(in_data);
      end
    end
    tokens_waiting = expected_tokens.size();
  end

endmodule

### bench/tb_action_call_tokenizer.sv
// testbench top for the action call tokenizer: command line stimulus, handshake idling, verdict
module tb_action_call_tokenizer;
  import act_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT      = 1_000_000;
  localparam int RAND_ITEMS = 1550;
  localparam int HOLD_AT    = 600;
  localparam int HOLD_LEN   = 300;

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count, tokens_waiting, beats_seen, tokens_seen, status_seen;
  int cycle_cnt;
  int rand_sent;
  int big_len;
  bit quiet_send;
  in_item_t line_q [$];

  action_call_tokenizer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  act_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .tokens_waiting (tokens_waiting),
    .beats_seen     (beats_seen),
    .tokens_seen    (tokens_seen),
    .status_seen    (status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // watchdog
  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("FAILED: results differ");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic bit blank_code(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] alnum_char();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'(r) + "0";
    if (r < 36) return 8'(r - 10) + "A";
    return 8'(r - 36) + "a";
  endfunction

  function automatic logic [7:0] space_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'd32 : 8'(9 + r);
  endfunction

  // anything that neither ends an unquoted parameter nor opens a quoted one
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = $urandom_range(0, 1) ? alnum_char() : 8'($urandom_range(0, 255));
    end while (blank_code(c) || c == CH_COMMA || c == CH_RPAREN || c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] inner_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic in_item_t beat_of(logic [7:0] c, logic e);
    in_item_t b;
    b.char_in = c;
    b.is_end  = e;
    return b;
  endfunction

  // one input beat; valid stays up until the handshake
  task send_beat(in_item_t b);
    int gap;
    gap = (quiet_send || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task send_end();
    send_beat(beat_of(8'($urandom_range(0, 255)), 1'b1));
  endtask

  task send_text(string s);
    foreach (s[i]) send_beat(beat_of(s[i], 1'b0));
  endtask

  task send_line();
    foreach (line_q[i]) send_beat(line_q[i]);
  endtask

  // line building
  task put(logic [7:0] c);
    line_q.push_back(beat_of(c, 1'b0));
  endtask

  task put_end();
    line_q.push_back(beat_of(8'($urandom_range(0, 255)), 1'b1));
  endtask

  task put_spaces(int max_n);
    repeat ($urandom_range(0, max_n)) put(space_char());
  endtask

  // short names mostly, now and then one near or past the name limit
  task add_name();
    int n;
    n = ($urandom_range(0, 99) < 95) ? $urandom_range(1, 8) : $urandom_range(60, 70);
    repeat (n) put(alnum_char());
  endtask

  task add_param(int len);
    int r;
    if (len == 0) return;
    if ($urandom_range(0, 1)) begin
      repeat (len) put(plain_char());
    end else begin
      put(CH_QUOTE);
      repeat (len) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          put(CH_BSLASH);
          put(CH_QUOTE);
        end else if (r == 1) begin
          put(CH_BSLASH);
          put(8'($urandom_range(0, 255)));
        end else put(inner_char());
      end
      put(CH_QUOTE);
    end
  endtask

  // name(params) with optional close; negative force values mean random
  task add_command(bit with_close, int force_par, int force_len);
    int n_par, r;
    add_name();
    if ($urandom_range(0, 3) == 0) put_spaces(2);
    put(CH_LPAREN);
    r = $urandom_range(0, 99);
    if (force_par >= 0) n_par = force_par;
    else if (r < 85) n_par = $urandom_range(0, 4);
    else if (r < 95) n_par = $urandom_range(5, 10);
    else n_par = $urandom_range(65, 70);
    for (int i = 0; i < n_par; i++) begin
      if (i > 0) put(CH_COMMA);
      if ($urandom_range(0, 3) == 0) put_spaces(2);
      if (force_len >= 0) add_param(force_len);
      else add_param((n_par > 10) ? 1 : $urandom_range(0, 6));
      if ($urandom_range(0, 3) == 0) put_spaces(2);
    end
    if (with_close) put(CH_RPAREN);
  endtask

  // one random line: mostly well formed, the rest broken, unterminated, noise or blank
  task build_line();
    int r, pos;
    line_q.delete();
    r = $urandom_range(0, 99);
    if (r < 55) begin
      if ($urandom_range(0, 1)) put_spaces(3);
      if ($urandom_range(0, 6) == 0) begin
        add_name();
        put_spaces(2);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          add_command(1'b1, -1, -1);
          put_spaces(2);
        end
      end
    end else if (r < 70) begin
      repeat ($urandom_range(1, 2)) add_command(1'b1, -1, -1);
      pos = $urandom_range(0, line_q.size() - 1);
      line_q[pos].char_in = 8'($urandom_range(0, 255));
    end else if (r < 80) begin
      add_command(1'b0, -1, -1);
    end else if (r < 90) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 9) == 0) put_end();
        else put(8'($urandom_range(0, 255)));
      end
    end else begin
      put_spaces(3);
    end
    put_end();
  endtask

  // receiver: random stalls, stall-free windows and one long hold-off
  initial begin : receiver
    int rcv_cycle, stall_left, hold_left;
    rcv_cycle  = 0;
    stall_left = 0;
    hold_left  = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      rcv_cycle++;
      if (rcv_cycle == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ((rcv_cycle / 400) % 4 == 3) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed lines: blank, full grammar with escapes and a chained command,
    // '(' expected, bad first character, ')' expected at end of line
    send_end();
    send_text("Az9(p,\"\\\"\\q\")b(x)");
    send_end();
    send_text("a-");
    send_end();
    send_beat(beat_of(8'hFF, 1'b0));
    send_end();
    send_text("a(");
    send_end();

    // parameter store overflow: five long parameters past the byte limit
    line_q.delete();
    add_command(1'b1, 5, 215);
    put_end();
    big_len = line_q.size();
    send_line();

    // saturating parameter count
    line_q.delete();
    add_command(1'b1, 68, 1);
    put_end();
    send_line();

    // every beat so far counts toward the total
    rand_sent = beats_seen;

    // random lines, about one in five sent without sender gaps
    while (rand_sent < RAND_ITEMS) begin
      build_line();
      quiet_send = ($urandom_range(0, 4) == 0);
      send_line();
      rand_sent += line_q.size();
    end
    quiet_send = 1'b0;
    in_valid <= 1'b0;

    // drain, then wait for zero-token beats still in flight
    while (tokens_waiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("run covered %0d input beats, %0d of them in the parameter overflow line",
             beats_seen, big_len);
    $display("%0d tokens checked, %0d statuses, one receiver hold of %0d cycles",
             tokens_seen, status_seen, HOLD_LEN);
    if (fail_count == 0 && tokens_waiting == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/act_pkg.sv
hdl/act_front.sv
hdl/act_fifo.sv
hdl/act_back.sv
hdl/action_call_tokenizer.sv
bench/act_checker.sv
bench/tb_action_call_tokenizer.sv
